>>> hdl/bm25_pkg.sv
// ============================================================================
// BM25 score accumulator package
// Shared types and constants of the BM25 weight and score accumulator.
// ============================================================================
package bm25_pkg;

   localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;

   // Configuration register indexes.
   localparam logic [1:0] REG_DOC_COUNT = 2'd0;
   localparam logic [1:0] REG_AVG_LEN   = 2'd1;
   localparam logic [1:0] REG_K_FACTOR  = 2'd2;
   localparam logic [1:0] REG_B_FACTOR  = 2'd3;

   typedef struct packed {
      logic [15:0] doc_id;
      logic [15:0] term_freq;
      logic [23:0] doc_freq;
      logic [23:0] doc_len;
      logic        first_term;
   } req_type;

   typedef struct packed {
      logic [15:0] out_doc_id;
      logic [23:0] term_weight;
      logic [31:0] doc_score;
      logic        score_saturated;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request and prepare operands
      logic log_init;   // start a logarithm (select by log_sel)
      logic log_sel;    // 0: doc_count, 1: doc_freq
      logic log_step;   // one squaring step
      logic log_save;   // store the finished logarithm
      logic idf_calc;   // form the idf from both logarithms
      logic norm_init;  // start norm division
      logic div_step;   // one restoring division step
      logic den_calc;   // no datapath action; numerator and denominator are combinational
      logic ratio_init; // start ratio division
      logic mul_calc;   // weight = idf * ratio
      logic mem_read;   // read the old score
      logic finish;     // form the result
   } cmd_type;

   typedef struct packed {
      logic absent;
   } sts_type;

endpackage

>>> hdl/bm25_if.sv
// ============================================================================
// BM25 stream interface
// Valid/ready channel carrying one packed payload.
// ============================================================================
interface bm25_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/bm25_score_accumulator_core.sv
// Each request runs through two 16-step logarithms, a 37-step norm division and
// a 61-step ratio division; both divisions share one bit-serial divider. An
// absent document (zero length) skips these and goes straight to the score read.
// One request is held at a time. Reset is synchronous and active high; it
// restores register defaults and the score store is undefined until written.
// ============================================================================
// BM25 score accumulator top level
// Configuration registers, controller and datapath.
// ============================================================================
module bm25_score_accumulator_core #(
   parameter int MaxDocs = 65536
) (
   input  logic        clock,
   input  logic        reset,
   bm25_if.sink        req,
   bm25_if.source      rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bm25_pkg::*;

   logic [23:0] doc_count_ff, avg_len_ff;
   logic [15:0] k_ff;
   logic [12:0] b_ff;
   cmd_type     cmd;
   sts_type     sts;
   rsp_type     rsp_data;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         doc_count_ff <= 24'd1;
         avg_len_ff   <= 24'd1;
         k_ff         <= 16'd8192;
         b_ff         <= 13'd3072;
      end else if (wr) begin
         case (csr_paddr[3:2])
            REG_DOC_COUNT: doc_count_ff <= csr_pwdata[23:0];
            REG_AVG_LEN:   avg_len_ff   <= csr_pwdata[23:0];
            REG_K_FACTOR:  k_ff         <= csr_pwdata[15:0];
            REG_B_FACTOR:  b_ff         <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (csr_paddr[3:2])
         REG_DOC_COUNT: csr_prdata = {8'd0, doc_count_ff};
         REG_AVG_LEN:   csr_prdata = {8'd0, avg_len_ff};
         REG_K_FACTOR:  csr_prdata = {16'd0, k_ff};
         REG_B_FACTOR:  csr_prdata = {19'd0, b_ff};
         default:       csr_prdata = '0;
      endcase
   end

   bm25_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .sts, .cmd
   );

   bm25_dpath #(.MaxDocs(MaxDocs)) u_dpath (
      .clock,
      .req         (req_type'(req.data)),
      .cmd,
      .doc_count   (doc_count_ff),
      .avg_doc_len (avg_len_ff),
      .k_factor    (k_ff),
      .b_factor    (b_ff),
      .sts,
      .rsp         (rsp_data)
   );

   assign rsp.data = rsp_data;
endmodule

>>> hdl/bm25_ctrl.sv
// ============================================================================
// BM25 controller
// Sequences logarithms, divisions, multiplication and the score update.
// ============================================================================
module bm25_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  bm25_pkg::sts_type  sts,
   output bm25_pkg::cmd_type  cmd
);
   import bm25_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOGN, S_LOGD, S_IDF, S_NORM, S_DEN, S_RATIO,
      S_MUL, S_READ, S_DONE, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOGN;
               cnt_in   = 6'd0;
            end
         end
         S_LOGN: begin
            if (cnt_ff == 6'd0) begin
               cmd.log_init = 1'b1;
               cnt_in = 6'd1;
            end else begin
               cmd.log_step = 1'b1;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd17) begin
                  cmd.log_step = 1'b0;
                  cmd.log_save = 1'b1;
                  state_in = S_LOGD;
                  cnt_in = 6'd0;
               end
            end
         end
         S_LOGD: begin
            cmd.log_sel = 1'b1;
            if (cnt_ff == 6'd0) begin
               cmd.log_init = 1'b1;
               cnt_in = 6'd1;
            end else begin
               cmd.log_step = 1'b1;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd17) begin
                  cmd.log_step = 1'b0;
                  cmd.log_save = 1'b1;
                  state_in = S_IDF;
               end
            end
         end
         S_IDF: begin
            cmd.idf_calc  = 1'b1;
            cmd.norm_init = 1'b1;
            state_in = S_NORM;
            cnt_in   = 6'd0;
         end
         S_NORM: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd36) state_in = S_DEN;
         end
         S_DEN: begin
            cmd.den_calc = 1'b1;
            state_in = S_RATIO;
            cnt_in = 6'd0;
         end
         S_RATIO: begin
            if (cnt_ff == 6'd0) begin
               cmd.ratio_init = 1'b1;
               cnt_in = 6'd1;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd61) state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_calc = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_LOGN && cnt_ff == 6'd0 && sts.absent) begin
         cmd.log_init = 1'b0;
         state_in = S_READ;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> hdl/bm25_dpath.sv
// ============================================================================
// BM25 datapath
// Logarithm unit, shared divider, multiplier and score memory.
// ============================================================================
module bm25_dpath #(
   parameter int MaxDocs = 65536
) (
   input  logic               clock,
   input  bm25_pkg::req_type  req,
   input  bm25_pkg::cmd_type  cmd,
   input  logic [23:0]        doc_count,
   input  logic [23:0]        avg_doc_len,
   input  logic [15:0]        k_factor,
   input  logic [12:0]        b_factor,
   output bm25_pkg::sts_type  sts,
   output bm25_pkg::rsp_type  rsp
);
   import bm25_pkg::*;

   // Only ids below both the store size and the 16-bit id range are held.
   localparam int Depth = (MaxDocs < 65536) ? MaxDocs : 65536;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   req_type     req_ff;
   logic [31:0] mant_ff;      // Q1.31 mantissa
   logic [20:0] log_ff;       // integer and fraction bits being built
   logic [20:0] logn_ff, logd_ff;
   logic [23:0] idf_ff;
   logic [63:0] quo_ff;       // divider quotient
   logic [63:0] rem_ff;
   logic [63:0] dsr_ff;
   logic [63:0] dvd_ff;       // shifted dividend
   logic [12:0] bc_ff;
   logic [31:0] weight_ff;
   logic [31:0] old_ff;
   rsp_type     rsp_ff;
   logic [31:0] scores [Depth];

   logic [23:0] log_x;
   logic [4:0]  lead;
   logic [63:0] sq;
   logic [64:0] rem_sh;
   logic [36:0] bl;
   logic [35:0] norm;
   logic [51:0] kn;
   logic [55:0] den;
   logic [32:0] num;
   logic [55:0] prod;
   logic [32:0] sum;
   logic [20:0] dlog;
   logic [52:0] idf_full;
   logic        in_range;

   assign sts.absent = (req_ff.doc_len == 24'd0);
   assign log_x  = cmd.log_sel ? req_ff.doc_freq : doc_count;
   assign sq     = mant_ff * mant_ff;
   assign rem_sh = {rem_ff, dvd_ff[63]};
   assign bl     = bc_ff * req_ff.doc_len;
   assign norm   = {23'd0, 13'd4096 - bc_ff} + quo_ff[35:0];
   assign kn     = k_factor * norm;
   assign den    = {16'd0, req_ff.term_freq, 24'd0} + {4'd0, kn};
   assign num    = req_ff.term_freq * ({1'b0, k_factor} + 17'd4096);
   assign prod   = idf_ff * quo_ff[31:0];
   assign sum    = {1'b0, old_ff} + {1'b0, weight_ff};
   assign dlog   = logn_ff - logd_ff;
   assign idf_full = dlog * LOG10_2_Q32;
   assign in_range = ({1'b0, req_ff.doc_id} < 17'(Depth));

   // Leading one position of the logarithm operand.
   always_comb begin
      lead = '0;
      for (int i = 0; i < 24; i++) if (log_x[i]) lead = 5'(i);
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         bc_ff  <= (b_factor > 13'd4096) ? 13'd4096 : b_factor;
      end
      if (cmd.log_init) begin
         mant_ff <= 32'({8'd0, log_x} << (5'd31 - lead));
         log_ff  <= {lead, 16'd0};
      end
      if (cmd.log_step) begin
         if (sq[63]) begin
            mant_ff <= sq[63:32];
            log_ff  <= {log_ff[20:16], log_ff[14:0], 1'b1};
         end else begin
            mant_ff <= sq[62:31];
            log_ff  <= {log_ff[20:16], log_ff[14:0], 1'b0};
         end
      end
      if (cmd.log_save) begin
         if (cmd.log_sel) logd_ff <= log_ff;
         else logn_ff <= log_ff;
      end
      if (cmd.idf_calc) begin
         if (req_ff.doc_freq == 24'd0 || req_ff.doc_freq > doc_count
             || logd_ff >= logn_ff)
            idf_ff <= '0;
         else
            idf_ff <= {3'd0, idf_full[52:32]};
      end
      // Restoring division: dividend shifted left one bit each step.
      if (cmd.norm_init) begin
         dvd_ff <= {bl, 27'd0};
         dsr_ff <= {40'd0, (avg_doc_len == 24'd0) ? 24'd1 : avg_doc_len};
         rem_ff <= '0;
         quo_ff <= '0;
      end
      // The 61-bit ratio dividend sits at the top of the shift register.
      if (cmd.ratio_init) begin
         dvd_ff <= {num, 28'd0, 3'd0};
         dsr_ff <= {8'd0, den};
         rem_ff <= '0;
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[62:0], 1'b0};
         if (rem_sh >= {1'b0, dsr_ff} && dsr_ff != 64'd0) begin
            rem_ff <= 64'(rem_sh - {1'b0, dsr_ff});
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
      if (cmd.mul_calc) begin
         if (quo_ff[63:32] != 32'd0 || prod[55:40] != 16'd0)
            weight_ff <= 32'hFFFFFF;
         else
            weight_ff <= {8'd0, prod[39:16]};
      end
      if (cmd.mem_read) old_ff <= in_range ? scores[req_ff.doc_id[AddrW-1:0]] : 32'd0;
      if (cmd.finish) begin
         rsp_ff.out_doc_id <= req_ff.doc_id;
         if (sts.absent) begin
            rsp_ff.term_weight     <= '0;
            rsp_ff.doc_score       <= '0;
            rsp_ff.score_saturated <= 1'b0;
         end else begin
            rsp_ff.term_weight <= weight_ff[23:0];
            if (req_ff.first_term) begin
               rsp_ff.doc_score       <= weight_ff;
               rsp_ff.score_saturated <= 1'b0;
            end else begin
               rsp_ff.doc_score       <= sum[32] ? 32'hFFFFFFFF : sum[31:0];
               rsp_ff.score_saturated <= sum[32];
            end
         end
      end
   end

   // Score store write.
   always_ff @(posedge clock) begin
      if (cmd.finish && in_range) begin
         scores[req_ff.doc_id[AddrW-1:0]] <= sts.absent ? 32'd0 :
            req_ff.first_term ? weight_ff : (sum[32] ? 32'hFFFFFFFF : sum[31:0]);
      end
   end

   assign rsp = rsp_ff;
endmodule

>>> hdl/bm25_checker.sv
// ============================================================================
// BM25 port checker
// Observes the top-level ports and checks response behavior over time.
// ============================================================================
module bm25_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [72:0] rsp_data
);
   // A response that is not taken holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // No new request is taken while a response waits.
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted with response pending");

   // A saturated score reads as all ones.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data[0] |-> rsp_data[32:1] == 32'hFFFFFFFF)
      else $error("saturation flag without clipped score");

   // Accepting a request removes ready in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after acceptance");
endmodule

bind bm25_score_accumulator_core bm25_checker u_checker (
   .clock, .reset,
   .req_valid (req.valid), .req_ready (req.ready),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

>>> bench/bm25_score_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// BM25 score checker
// Watches the request, response and register ports of the score accumulator,
// predicts every response from its own copy of the registers and the score
// store, and compares the responses field by field in order.
// ============================================================================
module bm25_score_checker
   import bm25_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bm25_if             req_mon,
   bm25_if             rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          saturated_count,
   output int          absent_count
);

   // Local copy of the registers and the score store.
   logic [23:0] n_docs;
   logic [23:0] avg_len;
   logic [15:0] k_val;
   logic [12:0] b_val;
   logic [31:0] score_mem [65536];

   rsp_type expected_rsps[$];

   initial begin
      fail_count      = 0;
      checked_count   = 0;
      saturated_count = 0;
      absent_count    = 0;
   end

   assign pending_count = expected_rsps.size();

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   // Base-2 logarithm in Q.16 by repeated squaring of the mantissa.
   function automatic logic [31:0] log2_fix(input logic [31:0] x);
      logic [4:0]  lead;
      logic [15:0] frac;
      logic [63:0] m;
      lead = 0;
      frac = 0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) lead = i[4:0];
      end
      m = 64'(x) << (31 - lead);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return {11'd0, lead, frac};
   endfunction

   // Inverse document frequency in Q.16; zero for a zero or excess df.
   function automatic logic [63:0] idf_fix(input logic [23:0] df);
      logic [31:0] ln, ld;
      if (df == 0 || df > n_docs) return 0;
      ln = log2_fix(32'(n_docs));
      ld = log2_fix(32'(df));
      if (ld >= ln) return 0;
      return (64'(ln - ld) * 64'(LOG10_2_Q32)) >> 32;
   endfunction

   // BM25 term weight in Q8.16, clipped to 24 bits.
   function automatic logic [23:0] term_weight_fix(input logic [15:0] tf,
                                                   input logic [23:0] df,
                                                   input logic [23:0] len);
      logic [63:0] avg, b, k, norm, den, num, ratio, w;
      avg   = (avg_len == 0) ? 64'd1 : 64'(avg_len);
      b     = (b_val > 13'd4096) ? 64'd4096 : 64'(b_val);
      k     = 64'(k_val);
      norm  = (64'd4096 - b) + (b * 64'(len)) / avg;
      den   = (64'(tf) << 24) + k * norm;
      num   = 64'(tf) * (k + 64'd4096);
      ratio = (den != 0) ? (num << 28) / den : 64'd0;
      w     = (idf_fix(df) * ratio) >> 16;
      return (w > 64'hFF_FFFF) ? 24'hFF_FFFF : w[23:0];
   endfunction

   // Register writes, in step with the block.
   always @(posedge clock) begin
      if (reset) begin
         n_docs  <= 24'd1;
         avg_len <= 24'd1;
         k_val   <= 16'd8192;
         b_val   <= 13'd3072;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[3:2])
            REG_DOC_COUNT: n_docs  <= csr_pwdata[23:0];
            REG_AVG_LEN:   avg_len <= csr_pwdata[23:0];
            REG_K_FACTOR:  k_val   <= csr_pwdata[15:0];
            REG_B_FACTOR:  b_val   <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // Predict the response of each accepted request.
   always @(posedge clock) begin
      req_type rq;
      rsp_type ex;
      logic [32:0] sum;
      if (!reset && req_mon.valid && req_mon.ready) begin
         rq = req_type'(req_mon.data);
         ex = '0;
         ex.out_doc_id = rq.doc_id;
         if (rq.doc_len != 0) begin
            ex.term_weight = term_weight_fix(rq.term_freq, rq.doc_freq, rq.doc_len);
            if (rq.first_term) begin
               ex.doc_score = 32'(ex.term_weight);
            end else begin
               sum = 33'(score_mem[rq.doc_id]) + 33'(ex.term_weight);
               if (sum[32]) begin
                  ex.doc_score = 32'hFFFF_FFFF;
                  ex.score_saturated = 1'b1;
               end else begin
                  ex.doc_score = sum[31:0];
               end
            end
         end
         score_mem[rq.doc_id] = ex.doc_score;
         expected_rsps.push_back(ex);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type got, ex;
      if (!reset && rsp_mon.valid && rsp_mon.ready) begin
         got = rsp_type'(rsp_mon.data);
         if (expected_rsps.size() == 0) begin
            $display("%0t: response for doc %0d with no request pending", $time,
                     got.out_doc_id);
            fail_count++;
         end else begin
            ex = expected_rsps.pop_front();
            checked_count++;
            if (ex.score_saturated) saturated_count++;
            if (ex.term_weight == 0 && ex.doc_score == 0) absent_count++;
            if (got.out_doc_id != ex.out_doc_id)
               report("out_doc_id", 32'(got.out_doc_id), 32'(ex.out_doc_id));
            if (got.term_weight != ex.term_weight)
               report("term_weight", 32'(got.term_weight), 32'(ex.term_weight));
            if (got.doc_score != ex.doc_score)
               report("doc_score", got.doc_score, ex.doc_score);
            if (got.score_saturated != ex.score_saturated)
               report("score_saturated", 32'(got.score_saturated),
                      32'(ex.score_saturated));
         end
      end
   end

endmodule

>>> bench/tb_bm25_score_accumulator_core.sv
`timescale 1ns / 100ps
// ============================================================================
// BM25 score accumulator testbench
// Drives directed and random requests through several register settings and
// idling patterns, with one long response stall; a checker predicts and
// compares every response.
// ============================================================================
module tb_bm25_score_accumulator_core;
   import bm25_pkg::*;

   localparam int IdleNone = 0;
   localparam int IdleSend = 1;
   localparam int IdleRecv = 2;
   localparam int IdleBoth = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, pending_count, checked_count, saturated_count, absent_count;
   int idle_mode = IdleNone;
   bit stall_go = 1'b0;
   bit stall_done = 1'b0;
   int stall_left = 0;
   bit doc_written [65536];
   logic [23:0] cur_docs, cur_avg;

   bm25_if #(.Width($bits(req_type))) req_ch ();
   bm25_if #(.Width($bits(rsp_type))) rsp_ch ();

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   bm25_score_accumulator_core DUT (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   bm25_score_checker score_check (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending_count(pending_count),
      .checked_count(checked_count), .saturated_count(saturated_count),
      .absent_count(absent_count)
   );

   // Response side: random stalls under IdleRecv/IdleBoth, plus one long hold-off.
   always @(posedge clock) begin
      if (stall_go && !stall_done && stall_left == 0) begin
         stall_left <= 1500;
         stall_done <= 1'b1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_mode == IdleRecv) begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 67);
      end else if (idle_mode == IdleBoth) begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 22);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Register write: setup cycle, then access cycle.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Wait until every response is in, then let the block settle.
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_regs(input logic [23:0] n, input logic [23:0] avg,
                           input logic [15:0] k, input logic [12:0] b);
      drain();
      write_reg(REG_DOC_COUNT, 32'(n));
      write_reg(REG_AVG_LEN, 32'(avg));
      write_reg(REG_K_FACTOR, 32'(k));
      write_reg(REG_B_FACTOR, 32'(b));
      cur_docs = n;
      cur_avg  = avg;
   endtask

   // Offer one request and hold it until it is taken.
   task automatic send(input req_type rq);
      int gap;
      gap = (idle_mode == IdleSend) ? 67 : (idle_mode == IdleBoth) ? 22 : 0;
      while ($urandom_range(0, 99) < gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= rq;
      if (rq.doc_len == 0 || rq.first_term) doc_written[rq.doc_id] = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic req_type make_req(input logic [15:0] id, input logic [15:0] tf,
                                        input logic [23:0] df, input logic [23:0] len,
                                        input logic first);
      req_type rq;
      rq.doc_id = id;
      rq.term_freq = tf;
      rq.doc_freq = df;
      rq.doc_len = len;
      rq.first_term = first;
      return rq;
   endfunction

   // Random request; ids mostly from a small pool so that scores accumulate.
   function automatic req_type rand_req(input int pool, input bit heavy);
      req_type rq;
      int pick;
      pick = $urandom_range(0, 99);
      if (pool == 1) rq.doc_id = 16'd7;
      else if (pick < 90) rq.doc_id = 16'($urandom_range(0, pool - 1));
      else if (pick < 95) rq.doc_id = 16'hFFFF;
      else rq.doc_id = 16'($urandom);
      if (heavy) begin
         rq.term_freq = 16'hFFFF;
         rq.doc_freq  = 24'd1;
         rq.doc_len   = 24'($urandom_range(1, 32'(cur_avg)));
      end else begin
         case ($urandom_range(0, 3))
            0: rq.term_freq = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'hFFFF;
            1: rq.term_freq = 16'($urandom_range(1, 20));
            default: rq.term_freq = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: rq.doc_freq = ($urandom_range(0, 1) != 0) ? 24'd0 : 24'd1;
            1: rq.doc_freq = 24'($urandom);
            2: rq.doc_freq = cur_docs + 24'($urandom_range(1, 100));
            default: rq.doc_freq = 24'($urandom_range(1, (cur_docs == 0) ? 1 :
                                                      32'(cur_docs)));
         endcase
         case ($urandom_range(0, 9))
            0: rq.doc_len = 24'd0;
            1: rq.doc_len = ($urandom_range(0, 1) != 0) ? 24'd1 : 24'hFF_FFFF;
            2: rq.doc_len = 24'($urandom);
            default: rq.doc_len = 24'($urandom_range(1, 2 * 32'(cur_avg) + 1));
         endcase
      end
      // The hammered document never restarts, so its score climbs to the ceiling.
      rq.first_term = !doc_written[rq.doc_id] ||
                      (!heavy && ($urandom_range(0, 99) < 12));
      return rq;
   endfunction

   task automatic run_random(input int count, input int pool, input bit heavy);
      for (int i = 0; i < count; i++) begin
         send(rand_req(pool, heavy));
         if (stall_go && i == 20) stall_go = stall_go;
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: overwrite, accumulation, extremes and special cases.
      set_regs(24'd1000, 24'd300, 16'd8192, 13'd3072);
      send(make_req(16'd0, 16'd3, 24'd10, 24'd300, 1'b1));
      send(make_req(16'd0, 16'hFFFF, 24'd1, 24'hFF_FFFF, 1'b0));
      send(make_req(16'd0, 16'd5, 24'd0, 24'd300, 1'b0));
      send(make_req(16'd0, 16'd5, 24'd2000, 24'd300, 1'b0));
      send(make_req(16'd0, 16'd5, 24'hFF_FFFF, 24'd1, 1'b0));
      send(make_req(16'd0, 16'd5, 24'd10, 24'd0, 1'b0));
      send(make_req(16'hFFFF, 16'd0, 24'd1000, 24'd1, 1'b1));
      send(make_req(16'hFFFF, 16'd7, 24'd999, 24'd600, 1'b0));
      send(make_req(16'd1, 16'd1, 24'd1, 24'd1, 1'b1));
      send(make_req(16'd1, 16'd1, 24'd500, 24'd0, 1'b1));
      send(make_req(16'd2, 16'hAAAA, 24'h55_5555, 24'hAA_AAAA, 1'b1));
      send(make_req(16'hAAAA, 16'h5555, 24'd3, 24'h55_5555, 1'b1));
      req_ch.valid <= 1'b0;
      @(posedge clock);
      run_random(150, 64, 1'b0);

      set_regs(24'hFF_FFFF, 24'd1, 16'd0, 13'd0);
      idle_mode = IdleSend;
      run_random(200, 64, 1'b0);

      // Long response stall while requests keep coming.
      set_regs(24'd1, 24'hFF_FFFF, 16'hFFFF, 13'd4096);
      idle_mode = IdleRecv;
      stall_go = 1'b1;
      run_random(250, 64, 1'b0);

      set_regs(24'd0, 24'd0, 16'd4096, 13'h1FFF);
      idle_mode = IdleBoth;
      run_random(200, 64, 1'b0);

      // One document hammered with large weights until its score clips.
      set_regs(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 13'd4096);
      idle_mode = IdleNone;
      run_random(560, 1, 1'b1);

      set_regs(24'd500000, 24'd700, 16'd12000, 13'd2000);
      idle_mode = IdleSend;
      run_random(250, 256, 1'b0);
      idle_mode = IdleRecv;
      run_random(200, 256, 1'b0);
      idle_mode = IdleBoth;
      run_random(200, 256, 1'b0);

      drain();
      $display("Checked %0d responses over 6 register settings and 4 idling patterns;",
               checked_count);
      $display("%0d responses clipped at the score ceiling, %0d with zero weight and score.",
               saturated_count, absent_count);
      if (fail_count == 0) begin
         $display("bm25_score_accumulator_core test passed");
      end else begin
         $display("bm25_score_accumulator_core test failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #50ms;
      $display("bm25_score_accumulator_core test failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/bm25_pkg.sv
hdl/bm25_if.sv
hdl/bm25_ctrl.sv
hdl/bm25_dpath.sv
hdl/bm25_score_accumulator_core.sv
hdl/bm25_checker.sv
bench/bm25_score_checker.sv
bench/tb_bm25_score_accumulator_core.sv
